// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// Concurrent assertion helpers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked only while rst_n is high
`define PT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PT_ASSERT(lbl, prop, msg)
`define PT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/dpot_pkg.sv -----
// ----------------------------------------------------------------------------
// dpot_pkg
// Shared types, register indexes and widths of the point outside test.
// ----------------------------------------------------------------------------
package dpot_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W      = 15;
  localparam int CON_W      = 16;
  localparam int OUT_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_RADIUS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_SIZE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAPER_LEN          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DITCH_DEPTH_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DITCH_WIDTH        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DITCH_OUTER_RADIUS = 3'd7;

  typedef struct packed {
    logic [REG_W-1:0] crystal_length;
    logic [REG_W-1:0] crystal_radius;
    logic [REG_W-1:0] top_edge_radius;
    logic [CON_W-1:0] contact_len;
    logic [CON_W-1:0] contact_rad;
    logic [REG_W-1:0] taper_len;
    logic [REG_W-1:0] ditch_depth_len;
    logic [REG_W-1:0] ditch_width;
    logic [REG_W-1:0] ditch_outer_radius;
  } cfg_t;

  typedef struct packed {
    logic z_out;   // z at or beyond the crystal length or below zero
    logic te_en;   // z above the start of the top edge rounding
  } front_flags_t;

endpackage

// ----- rtl/core/dpot_front.sv -----
// ----------------------------------------------------------------------------
// dpot_front
// Squares of x, y and of the top edge offset, radicands for both roots.
// ----------------------------------------------------------------------------
module dpot_front #(
  parameter int CB = 16,
  parameter int RB = 16,
  parameter int DW = 18
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CB-1:0]   x_pos,
  input  logic signed [CB-1:0]   y_pos,
  input  logic signed [CB-1:0]   z_pos,
  input  dpot_pkg::cfg_t         cfg,
  output logic [2*RB-1:0]        rad_main,
  output logic [2*RB-1:0]        rad_te,
  output logic signed [CB-1:0]   z_out,
  output dpot_pkg::front_flags_t flags
);

  localparam int RW = 2 * RB;
  localparam int PW = 2 * DW;
  localparam int BW = 2 * dpot_pkg::REG_W;

  // stage a
  logic signed [2*CB-1:0] xx_s, yy_s;
  logic signed [DW-1:0]   z_w, len_w, teb_w, knee_w;

  logic [2*CB-1:0]        xx_a_r, yy_a_r;
  logic signed [CB-1:0]   z_a_r;
  logic signed [DW-1:0]   d_a_r;
  dpot_pkg::front_flags_t fl_a_r;

  assign xx_s   = x_pos * x_pos;
  assign yy_s   = y_pos * y_pos;
  assign z_w    = DW'(z_pos);
  assign len_w  = DW'({1'b0, cfg.crystal_length});
  assign teb_w  = DW'({1'b0, cfg.top_edge_radius});
  assign knee_w = len_w - teb_w;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_a_r       <= xx_s;
      yy_a_r       <= yy_s;
      z_a_r        <= z_pos;
      d_a_r        <= z_w - knee_w;
      fl_a_r.z_out <= (z_w >= len_w) || z_pos[CB-1];
      fl_a_r.te_en <= z_w > knee_w;
    end
  end

  // stage b
  logic signed [PW-1:0]   dd_s;
  logic [BW-1:0]          bb_s;

  logic [2*CB-1:0]        sum_b_r;
  logic [PW-1:0]          dd_b_r;
  logic [BW-1:0]          bb_b_r;
  logic signed [CB-1:0]   z_b_r;
  dpot_pkg::front_flags_t fl_b_r;

  assign dd_s = d_a_r * d_a_r;
  assign bb_s = cfg.top_edge_radius * cfg.top_edge_radius;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_b_r <= xx_a_r + yy_a_r;
      dd_b_r  <= dd_s;
      bb_b_r  <= bb_s;
      z_b_r   <= z_a_r;
      fl_b_r  <= fl_a_r;
    end
  end

  // stage c: root argument of the top edge, clamped at zero
  logic signed [PW:0]     te_diff;

  logic [RW-1:0]          rad_main_c_r, rad_te_c_r;
  logic signed [CB-1:0]   z_c_r;
  dpot_pkg::front_flags_t fl_c_r;

  assign te_diff = $signed((PW+1)'(bb_b_r)) - $signed((PW+1)'(dd_b_r));

  always_ff @(posedge clk) begin
    if (en) begin
      rad_main_c_r <= RW'(sum_b_r);
      rad_te_c_r   <= te_diff[PW] ? '0 : te_diff[RW-1:0];
      z_c_r        <= z_b_r;
      fl_c_r       <= fl_b_r;
    end
  end

  assign rad_main = rad_main_c_r;
  assign rad_te   = rad_te_c_r;
  assign z_out    = z_c_r;
  assign flags    = fl_c_r;

endmodule

// ----- rtl/core/dpot_sqrt.sv -----
// ----------------------------------------------------------------------------
// dpot_sqrt
// Pipelined truncating integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dpot_sqrt #(
  parameter int RB = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RB-1:0] rad,
  output logic [RB-1:0]   root
);

  localparam int RW = 2 * RB;
  localparam int MW = RB + 3;

  logic [MW-1:0] rem_r  [RB-1];
  logic [RW-1:0] rad_r  [RB-1];
  logic [RB-1:0] root_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_step
    logic [MW-1:0] rem_p, rem_sh, trial;
    logic [RB-1:0] root_p;
    logic [RW-1:0] rad_p;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign rad_p  = rad_r[i-1];
    end

    // remainder never exceeds 2*root, so its top two bits are always clear
    assign rem_sh = {rem_p[MW-3:0], rad_p[RW-1 -: 2]};
    assign trial  = MW'({root_p, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_p[RB-2:0], ge};
      end
    end

    if (i < RB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= ge ? rem_sh - trial : rem_sh;
          rad_r[i] <= {rad_p[RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[RB-1];

endmodule

// ----- rtl/core/dpot_back.sv -----
// ----------------------------------------------------------------------------
// dpot_back
// Shape tests on the radius and the ordered decision of the outside bit.
// ----------------------------------------------------------------------------
module dpot_back #(
  parameter int CB        = 16,
  parameter int RB        = 16,
  parameter int DW        = 18,
  parameter int BULLETIZE = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [RB-1:0]          r_in,
  input  logic [RB-1:0]          s_in,
  input  logic signed [CB-1:0]   z_in,
  input  dpot_pkg::front_flags_t fl_in,
  input  dpot_pkg::cfg_t         cfg,
  output logic                   outside
);

  localparam int PW = 2 * DW;
  localparam int LW = 2 * dpot_pkg::CON_W;

  typedef struct packed {
    logic z_out;
    logic r_out;
    logic te_out;
    logic c_in;
    logic c_early;
    logic taper_out;
    logic ditch_out;
  } back_flags_t;

  function automatic logic signed [DW-1:0] widen(input logic [dpot_pkg::CON_W-1:0] v);
    widen = DW'({1'b0, v});
  endfunction

  // stage d
  logic signed [DW-1:0] r_w, s_w, z_w, len_w, rad_w, teb_w, cl_w, cr_w;
  logic signed [DW-1:0] tl_w, dep_w, dwid_w, dor_w, a_w, p_w, q_w;
  logic                 long_contact;
  logic [dpot_pkg::CON_W-1:0] lim;
  back_flags_t          fl_d;

  assign r_w    = DW'({1'b0, r_in});
  assign s_w    = DW'({1'b0, s_in});
  assign z_w    = DW'(z_in);
  assign len_w  = widen({1'b0, cfg.crystal_length});
  assign rad_w  = widen({1'b0, cfg.crystal_radius});
  assign teb_w  = widen({1'b0, cfg.top_edge_radius});
  assign cl_w   = widen(cfg.contact_len);
  assign cr_w   = widen(cfg.contact_rad);
  assign tl_w   = widen({1'b0, cfg.taper_len});
  assign dep_w  = widen({1'b0, cfg.ditch_depth_len});
  assign dwid_w = widen({1'b0, cfg.ditch_width});
  assign dor_w  = widen({1'b0, cfg.ditch_outer_radius});

  // a long contact rounds off its lower end, a short one its outer rim
  assign long_contact = cl_w > cr_w;
  assign a_w = long_contact ? cl_w - cr_w : cr_w - cl_w;
  assign p_w = long_contact ? z_w - a_w : z_w;
  assign q_w = long_contact ? r_w : r_w - a_w;
  assign lim = long_contact ? cfg.contact_rad : cfg.contact_len;

  always_comb begin
    fl_d.z_out     = fl_in.z_out;
    fl_d.r_out     = r_w > rad_w;
    fl_d.te_out    = fl_in.te_en && (r_w > rad_w - teb_w + s_w);
    fl_d.c_in      = (cfg.contact_rad != '0) && (z_w <= cl_w) && (r_w <= cr_w);
    fl_d.c_early   = long_contact ? (z_w < a_w) : (r_w < a_w);
    fl_d.taper_out = (cfg.taper_len != '0) && (z_w < tl_w) && (r_w > len_w - tl_w + z_w);
    fl_d.ditch_out = (cfg.ditch_depth_len != '0) && (z_w < dep_w) &&
                     (cfg.ditch_width != '0) && (cfg.ditch_outer_radius != '0) &&
                     (r_w < dor_w) && (r_w > dor_w - dwid_w);
  end

  logic signed [DW-1:0]       p_d_r, q_d_r;
  logic [dpot_pkg::CON_W-1:0] lim_d_r;
  back_flags_t                fl_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_d_r   <= p_w;
      q_d_r   <= q_w;
      lim_d_r <= lim;
      fl_d_r  <= fl_d;
    end
  end

  // stage e
  logic signed [PW-1:0] pp_s, qq_s;
  logic [LW-1:0]        ll_s;

  logic [PW-1:0]        pp_e_r, qq_e_r;
  logic [LW-1:0]        ll_e_r;
  back_flags_t          fl_e_r;

  assign pp_s = p_d_r * p_d_r;
  assign qq_s = q_d_r * q_d_r;
  assign ll_s = lim_d_r * lim_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_e_r <= pp_s;
      qq_e_r <= qq_s;
      ll_e_r <= ll_s;
      fl_e_r <= fl_d_r;
    end
  end

  // stage f
  logic [PW:0] pq_sum;
  logic        in_round, bullet_out, result;
  logic        outside_r;

  assign pq_sum     = (PW+1)'(pp_e_r) + (PW+1)'(qq_e_r);
  assign in_round   = pq_sum < (PW+1)'(ll_e_r);
  assign bullet_out = (BULLETIZE != 0) ? (fl_e_r.c_early || in_round) : 1'b1;

  always_comb begin
    if (fl_e_r.z_out || fl_e_r.r_out || fl_e_r.te_out) begin
      result = 1'b1;
    end else if (fl_e_r.c_in) begin
      result = bullet_out;
    end else begin
      result = fl_e_r.taper_out || fl_e_r.ditch_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outside_r <= result;
    end
  end

  assign outside = outside_r;

endmodule

// ----- rtl/core/detector_point_outside_test.sv -----
// ----------------------------------------------------------------------------
// detector_point_outside_test
// Decides whether a point lies outside a point-contact crystal.
// ----------------------------------------------------------------------------
// One point (x, y, z in signed fixed point) enters per beat and leaves as one
// outside bit, one point per cycle sustained while the output is not stalled.
// Two digit-by-digit square root pipelines, one result bit per stage,
// produce the radius and the top edge root side by side. The whole pipeline
// advances together; a two-entry output buffer lets one more beat in after
// the output stalls, then in_tready drops until it drains. Registers may be
// written only while no beat is in flight.
`include "assert_macros.svh"

module detector_point_outside_test #(
  parameter int COORD_BITS        = 16,
  parameter int BULLETIZE_CONTACT = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_pos, y_pos, z_pos from bit 0 up, zero padded to whole bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // outside in bit 0, rest zero
  output logic [dpot_pkg::OUT_W-1:0]           out_tdata,
  input  logic                                 cfg_we,
  input  logic [dpot_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpot_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int RB = (CB > 15) ? CB : 15;
  localparam int DW = ((CB > 16) ? CB : 16) + 2;
  localparam int NS = RB + 6;

  // configuration registers
  dpot_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpot_pkg::REG_CRYSTAL_LENGTH: begin
          cfg_r.crystal_length <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_CRYSTAL_RADIUS: begin
          cfg_r.crystal_radius <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_TOP_EDGE_RADIUS: begin
          cfg_r.top_edge_radius <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_CONTACT_SIZE: begin
          cfg_r.contact_len <= cfg_wdata[2*dpot_pkg::CON_W-1:dpot_pkg::CON_W];
          cfg_r.contact_rad <= cfg_wdata[dpot_pkg::CON_W-1:0];
        end
        dpot_pkg::REG_TAPER_LEN: begin
          cfg_r.taper_len <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_DITCH_DEPTH_LEN: begin
          cfg_r.ditch_depth_len <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_DITCH_WIDTH: begin
          cfg_r.ditch_width <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        dpot_pkg::REG_DITCH_OUTER_RADIUS: begin
          cfg_r.ditch_outer_radius <= cfg_wdata[dpot_pkg::REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control: everything moves while the skid entry is free
  logic          en;
  logic [NS-1:0] v_r;
  logic          sk_v_r, out_v_r;

  assign en        = !sk_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // datapath
  logic [2*RB-1:0]        rad_main, rad_te;
  logic signed [CB-1:0]   z_c;
  dpot_pkg::front_flags_t fl_c;
  logic [RB-1:0]          r_root, s_root;
  logic                   outside;

  dpot_front #(
    .CB (CB),
    .RB (RB),
    .DW (DW)
  ) u_front (
    .clk      (clk),
    .en       (en),
    .x_pos    ($signed(in_tdata[CB-1:0])),
    .y_pos    ($signed(in_tdata[2*CB-1:CB])),
    .z_pos    ($signed(in_tdata[3*CB-1:2*CB])),
    .cfg      (cfg_r),
    .rad_main (rad_main),
    .rad_te   (rad_te),
    .z_out    (z_c),
    .flags    (fl_c)
  );

  dpot_sqrt #(
    .RB (RB)
  ) u_sqrt_radius (
    .clk  (clk),
    .en   (en),
    .rad  (rad_main),
    .root (r_root)
  );

  dpot_sqrt #(
    .RB (RB)
  ) u_sqrt_edge (
    .clk  (clk),
    .en   (en),
    .rad  (rad_te),
    .root (s_root)
  );

  // z and flags ride alongside the root stages
  logic signed [CB-1:0]   z_sb_r  [RB];
  dpot_pkg::front_flags_t fl_sb_r [RB];

  always_ff @(posedge clk) begin
    if (en) begin
      z_sb_r[0]  <= z_c;
      fl_sb_r[0] <= fl_c;
      for (int k = 1; k < RB; k++) begin
        z_sb_r[k]  <= z_sb_r[k-1];
        fl_sb_r[k] <= fl_sb_r[k-1];
      end
    end
  end

  dpot_back #(
    .CB        (CB),
    .RB        (RB),
    .DW        (DW),
    .BULLETIZE (BULLETIZE_CONTACT)
  ) u_back (
    .clk     (clk),
    .en      (en),
    .r_in    (r_root),
    .s_in    (s_root),
    .z_in    (z_sb_r[RB-1]),
    .fl_in   (fl_sb_r[RB-1]),
    .cfg     (cfg_r),
    .outside (outside)
  );

  // output register with one skid entry
  logic out_d_r, sk_d_r;
  logic out_v_nxt, sk_v_nxt, out_d_nxt, sk_d_nxt;
  logic take, push;

  assign take = out_v_r && out_tready;
  assign push = en && v_r[NS-1];

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_d_nxt = out_d_r;
    sk_d_nxt  = sk_d_r;
    if (sk_v_r) begin
      if (take) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = outside;
      end else begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = outside;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(dpot_pkg::OUT_W-1){1'b0}}, out_d_r};

  `PT_ASSERT(a_skid_behind_out, sk_v_r |-> out_v_r, "skid holds a beat but output is empty")
  `PT_ASSERT(a_skid_fill_on_stall, $rose(sk_v_r) |-> $past(out_v_r && !out_tready), "skid filled without a stalled output")
  `PT_ASSERT(a_frozen_while_full, sk_v_r |=> $stable(v_r), "pipeline moved while skid was full")
  `PT_ASSERT_RST(a_reset_clears, !rst_n |=> (v_r == '0) && !out_v_r && !sk_v_r, "reset left a beat in flight")

endmodule

// ----- bench/detector_point_outside_test_tb.sv -----
// ----------------------------------------------------------------------------
// detector_point_outside_test_tb
// Streams points through the outside test and checks each verdict against a
// geometry model of the crystal. The run covers several crystal shapes, the
// extreme register values, and random idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module detector_point_outside_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = 16;
  localparam int BULLETIZE  = 1;
  localparam int IN_W       = ((3*COORD_W+7)/8)*8;
  localparam int PIPE_DEPTH = 23;
  localparam int PER_MODE   = 35;

  // holds the current crystal geometry and the verdicts still to come out
  class verdict_ledger;
    dpot_pkg::cfg_t geom;
    bit             verdict_q[$];
    int             errors;

    function new();
      geom   = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [dpot_pkg::CFG_IDX_W-1:0]  idx,
                            logic [dpot_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dpot_pkg::REG_CRYSTAL_LENGTH:     geom.crystal_length     = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_CRYSTAL_RADIUS:     geom.crystal_radius     = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_TOP_EDGE_RADIUS:    geom.top_edge_radius    = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_CONTACT_SIZE: begin
          geom.contact_len = data[31:16];
          geom.contact_rad = data[15:0];
        end
        dpot_pkg::REG_TAPER_LEN:          geom.taper_len          = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_DITCH_DEPTH_LEN:    geom.ditch_depth_len    = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_DITCH_WIDTH:        geom.ditch_width        = data[dpot_pkg::REG_W-1:0];
        dpot_pkg::REG_DITCH_OUTER_RADIUS: geom.ditch_outer_radius = data[dpot_pkg::REG_W-1:0];
        default: ;
      endcase
    endfunction

    // truncating square root, one result bit per two radicand bits
    static function longint root_floor(longint a);
      longint unsigned n;
      longint unsigned res;
      longint unsigned probe;
      if (a <= 0) return 0;
      n     = a;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe >>= 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n   = n - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe >>= 2;
      end
      return longint'(res);
    endfunction

    function bit predict_outside(logic signed [COORD_W-1:0] xp, yp, zp);
      longint x, y, z, r, len, rad, b, d, cl, cr, a, tl, dd, dw, dor;
      x   = xp;
      y   = yp;
      z   = zp;
      len = geom.crystal_length;
      rad = geom.crystal_radius;
      b   = geom.top_edge_radius;
      cl  = geom.contact_len;
      cr  = geom.contact_rad;
      tl  = geom.taper_len;
      dd  = geom.ditch_depth_len;
      dw  = geom.ditch_width;
      dor = geom.ditch_outer_radius;
      if (z >= len || z < 0) return 1;
      r = root_floor(x*x + y*y);
      if (r > rad) return 1;
      if (z > len - b) begin
        d = z - (len - b);
        if (r > (rad - b) + root_floor(b*b - d*d)) return 1;
      end
      // inside the contact's bounding cylinder the verdict is final
      if (cr > 0 && z <= cl && r <= cr) begin
        if (BULLETIZE == 0) return 1;
        if (cl > cr) begin
          a = cl - cr;
          return (z < a) || ((z-a)*(z-a) + r*r < cr*cr);
        end else begin
          a = cr - cl;
          return (r < a) || (z*z + (r-a)*(r-a) < cl*cl);
        end
      end
      // taper line is measured from the crystal length
      if (tl > 0 && z < tl && r > len - tl + z) return 1;
      if (dd > 0 && z < dd && dw > 0 && dor > 0 && r < dor && r > dor - dw) return 1;
      return 0;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] x, y, z);
      verdict_q.push_back(predict_outside(x, y, z));
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void check_verdict(logic [dpot_pkg::OUT_W-1:0] beat);
      bit want;
      if (verdict_q.size() == 0) begin
        $error("outside: expected no beat, actual %0b", beat[0]);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (beat[0] !== want) begin
        $error("outside: expected %0d, actual %0b", want, beat[0]);
        errors++;
      end
      if (beat[dpot_pkg::OUT_W-1:1] !== '0) begin
        $error("padding: expected 0, actual %0h", beat[dpot_pkg::OUT_W-1:1]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // x_pos, y_pos, z_pos from bit 0 up
  logic [IN_W-1:0]                 in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // outside in bit 0, rest zero
  logic [dpot_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_we = 1'b0;
  logic [dpot_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dpot_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  verdict_ledger ledger;

  detector_point_outside_test #(
    .COORD_BITS       (COORD_W),
    .BULLETIZE_CONTACT(BULLETIZE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_verdict(out_tdata);
  end

  initial begin
    #3_000_000;
    $display("detector_point_outside_test regression: fail");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint jitter(longint v);
    return v + longint'($urandom_range(6)) - 3;
  endfunction

  // keeps the low register bits and fills the ignored ones with noise
  function automatic logic [dpot_pkg::CFG_DATA_W-1:0] with_noise(longint v);
    logic [dpot_pkg::CFG_DATA_W-1:0] w;
    w = $urandom;
    w[dpot_pkg::REG_W-1:0] = v[dpot_pkg::REG_W-1:0];
    return w;
  endfunction

  task automatic put_reg(logic [dpot_pkg::CFG_IDX_W-1:0]  idx,
                         logic [dpot_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    ledger.write_reg(idx, data);
  endtask

  task automatic write_geometry(logic [31:0] len_w, rad_w, round_w, contact_w,
                                logic [31:0] taper_w, depth_w, width_w, outer_w);
    put_reg(dpot_pkg::REG_CRYSTAL_LENGTH, len_w);
    put_reg(dpot_pkg::REG_CRYSTAL_RADIUS, rad_w);
    put_reg(dpot_pkg::REG_TOP_EDGE_RADIUS, round_w);
    put_reg(dpot_pkg::REG_CONTACT_SIZE, contact_w);
    put_reg(dpot_pkg::REG_TAPER_LEN, taper_w);
    put_reg(dpot_pkg::REG_DITCH_DEPTH_LEN, depth_w);
    put_reg(dpot_pkg::REG_DITCH_WIDTH, width_w);
    put_reg(dpot_pkg::REG_DITCH_OUTER_RADIUS, outer_w);
    cfg_we <= 1'b0;
  endtask

  task automatic push_point(logic signed [COORD_W-1:0] x, y, z);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.note_point(x, y, z);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // mostly points near the boundaries of the current shape, some raw noise
  task automatic pick_point(output logic signed [COORD_W-1:0] x, y, z);
    longint len, rad, b, cl, cr, tl, dd, dw, dor, zt, rt, xt, yt;
    len = ledger.geom.crystal_length;
    rad = ledger.geom.crystal_radius;
    b   = ledger.geom.top_edge_radius;
    cl  = ledger.geom.contact_len;
    cr  = ledger.geom.contact_rad;
    tl  = ledger.geom.taper_len;
    dd  = ledger.geom.ditch_depth_len;
    dw  = ledger.geom.ditch_width;
    dor = ledger.geom.ditch_outer_radius;
    if ($urandom_range(99) < 15) begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      z = COORD_W'($urandom);
    end else begin
      case ($urandom_range(9))
        0:       zt = $urandom_range(len);
        1:       zt = jitter(len);
        2:       zt = jitter(0);
        3:       zt = len - b + $urandom_range(b);
        4:       zt = jitter(cl);
        5:       zt = jitter(tl);
        6:       zt = jitter(dd);
        7:       zt = $urandom_range(cl);
        default: zt = jitter(cl - cr);
      endcase
      case ($urandom_range(9))
        0:       rt = $urandom_range(rad);
        1:       rt = jitter(rad);
        2:       rt = jitter(cr);
        3:       rt = rad - b + $urandom_range(b);
        4:       rt = jitter(dor);
        5:       rt = jitter(dor - dw);
        6:       rt = jitter(len - tl + zt);
        7:       rt = $urandom_range(cr);
        default: rt = jitter(cr - cl);
      endcase
      if (rt < 0) rt = 0;
      if (rt > 46340) rt = 46340;
      xt = longint'($urandom_range(2*rt)) - rt;
      yt = verdict_ledger::root_floor(rt*rt - xt*xt);
      if ($urandom_range(1)) yt = -yt;
      x = clamp_coord(xt);
      y = clamp_coord(yt);
      z = clamp_coord(zt);
    end
  endtask

  task automatic random_burst();
    logic signed [COORD_W-1:0] x, y, z;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (PER_MODE) begin
        pick_point(x, y, z);
        push_point(x, y, z);
      end
    end
    drain();
  endtask

  task automatic random_geometry();
    longint len, rad, b, tl, dd, dw, dor;
    logic [31:0] contact;
    len = $urandom_range(32767, 16);
    rad = $urandom_range(32767, 16);
    case ($urandom_range(2))
      0:       b = 0;
      1:       b = $urandom_range((len < rad) ? len : rad);
      default: b = $urandom_range(32767);
    endcase
    case ($urandom_range(2))
      0:       contact = $urandom;
      1:       contact = {16'($urandom_range(len)), 16'($urandom_range(rad))};
      default: contact = {16'($urandom_range(len/8)), 16'($urandom_range(rad/8))};
    endcase
    tl  = $urandom_range(1) ? 0 : $urandom_range(len);
    dd  = $urandom_range(len);
    dw  = $urandom_range(rad);
    dor = $urandom_range(rad);
    write_geometry(with_noise(len), with_noise(rad), with_noise(b), contact,
                   with_noise(tl), with_noise(dd), with_noise(dw), with_noise(dor));
  endtask

  initial begin
    ledger = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all registers at reset: every point is outside
    push_point(0, 0, 0);
    push_point(-32768, -32768, -32768);
    push_point(32767, 32767, 32767);
    drain();

    // typical crystal, contact longer than its radius
    write_geometry(7680, 8960, 768, {16'd512, 16'd256}, 1280, 512, 768, 3072);
    push_point(0, 0, -1);
    push_point(0, 0, 7680);
    push_point(0, 0, 7679);
    push_point(8961, 0, 4000);
    push_point(8960, 0, 4000);
    push_point(-8900, 0, 7600);
    push_point(0, 8500, 7679);
    push_point(0, 0, 0);
    push_point(0, 0, 512);
    push_point(200, 0, 400);
    push_point(0, -256, 512);
    push_point(257, 0, 100);
    push_point(2700, 0, 100);
    push_point(-3072, 0, 100);
    push_point(2304, 0, 100);
    push_point(8000, 0, 100);
    push_point(6400, 0, 1279);
    push_point(-32768, 32767, 4000);
    push_point(0, -32768, 0);
    push_point(0, 0, 32767);
    drain();
    random_burst();

    // contact wider than long, no rounding, ditch off through zero width
    write_geometry(6400, 6400, 0, {16'd256, 16'd768}, 0, 400, 0, 2000);
    random_burst();
    // every register at its top value, ignored bits set
    write_geometry('1, '1, '1, '1, '1, '1, '1, '1);
    random_burst();
    // tiny crystal, contact length equal to its radius
    write_geometry(100, 100, 50, {16'd30, 16'd30}, 50, 40, 20, 60);
    random_burst();
    // contact off, full edge rounding, ditch wider than its outer radius
    write_geometry(5000, 3000, 3000, {16'd2000, 16'd0}, 4000, 5000, 4000, 1500);
    random_burst();

    repeat (6) begin
      random_geometry();
      random_burst();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("detector_point_outside_test regression: pass");
    end else begin
      $display("detector_point_outside_test regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dpot_pkg.sv
rtl/core/dpot_front.sv
rtl/core/dpot_sqrt.sv
rtl/core/dpot_back.sv
rtl/core/detector_point_outside_test.sv
bench/detector_point_outside_test_tb.sv
